// ===== rtl/font_package_verifier_unit_macros.svh =====
// assertion macros for the font package verifier
// used by the top level; no other dependencies
`ifndef FONT_PACKAGE_VERIFIER_UNIT_MACROS_SVH
`define FONT_PACKAGE_VERIFIER_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define FPV_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("font package verifier check failed");

// condition holds in the cycle after the trigger
`define FPV_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("font package verifier check failed");

`endif

// ===== rtl/fpv_pkg.sv =====
// shared types and constants for the font package verifier
// no dependencies
`default_nettype none

package fpv_pkg;

    // package layout
    localparam int HEADER_BYTES  = 32;
    localparam int CHECKED_BYTES = 23;
    localparam int HDR_IDX_W     = 5;

    // byte counter
    localparam int POS_W = 24;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // crc-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // verdict codes
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_HEADER = 2'd1;
    localparam logic [1:0] VERDICT_LENGTH = 2'd2;
    localparam logic [1:0] VERDICT_CRC    = 2'd3;

    // register map
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRC      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPHS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_HT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BPP      = 3'd6;

    // configuration seen by the datapath
    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [22:0] payload_bytes;
        logic [31:0] expected_crc;
        logic [31:0] glyph_total;
        logic [15:0] pixel_height;
        logic [7:0]  bits_per_pixel;
    } fpv_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/fpv_ifs.sv =====
// valid/ready channel interfaces for package bytes and results
// depends on fpv_pkg
`default_nettype none

// package byte channel
interface fpv_byte_if import fpv_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// result channel
interface fpv_result_if import fpv_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [31:0] computed_crc;

    modport source (output valid, output verdict, output computed_crc, input ready);
    modport sink   (input valid, input verdict, input computed_crc, output ready);
endinterface

`default_nettype wire

// ===== rtl/font_package_verifier_unit.sv =====
// font package verifier: header check, payload crc-32 and final verdict
// depends on fpv_pkg, fpv_ifs, fpv_regs and the macros header
`default_nettype none
`include "font_package_verifier_unit_macros.svh"

// Takes one package byte per cycle with no gaps needed between packages: the
// byte-wide CRC-32 update and the header compare are both combinational.
// The result for a package appears on result_out in the cycle after its final
// byte is transferred and sits in an output register; byte_in stalls only while
// that register holds a result that has not been taken. Bytes without the final
// flag produce no result. No clearing pass is needed after reset.
// Registers: magic 0x00, version 0x04, payload bytes 0x08, expected crc 0x0C,
// glyph count 0x10, pixel height 0x14, bits per pixel 0x18.
module font_package_verifier_unit
    import fpv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    fpv_byte_if.sink                   byte_in,
    fpv_result_if.source               result_out
);

    fpv_cfg_t cfg;

    fpv_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // one byte through the reflected crc
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // byte lane of a little-endian word
    function automatic logic [7:0] lane8(input logic [31:0] word, input logic [1:0] sel);
        return word[{sel, 3'b000} +: 8];
    endfunction

    // expected value of a checked header byte
    function automatic logic [7:0] header_expect(input logic [HDR_IDX_W-1:0] idx,
                                                 input fpv_cfg_t c);
        logic [31:0] hdr_size;
        hdr_size = {16'd0, 16'(HEADER_BYTES)};
        priority if (idx < 5'd4)
            return lane8(c.magic_word, idx[1:0]);
        else if (idx < 5'd6)
            return lane8({16'd0, c.format_version}, {1'b0, idx[0]});
        else if (idx < 5'd8)
            return lane8(hdr_size, {1'b0, idx[0]});
        else if (idx < 5'd12)
            return lane8({9'd0, c.payload_bytes}, idx[1:0]);
        else if (idx < 5'd16)
            return lane8(c.expected_crc, idx[1:0]);
        else if (idx < 5'd20)
            return lane8(c.glyph_total, idx[1:0]);
        else if (idx < 5'd22)
            return lane8({16'd0, c.pixel_height}, idx[1:0]);
        else
            return c.bits_per_pixel;
    endfunction

    logic [POS_W-1:0] byte_position_reg;
    logic             header_agrees_reg;
    logic [31:0]      running_crc_reg;
    logic             out_valid_reg;
    logic [1:0]       verdict_reg;
    logic [31:0]      computed_crc_reg;

    logic             in_xfer;
    logic             in_header;
    logic             byte_checked;
    logic [POS_W-1:0] byte_position_next;
    logic             header_agrees_next;
    logic [31:0]      running_crc_next;
    logic [31:0]      crc_final;
    logic [POS_W-1:0] expected_length;
    logic [1:0]       verdict_next;

    // input is free whenever the result register is empty or draining
    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign in_xfer       = byte_in.valid && byte_in.ready;

    // per-byte update
    always_comb
    begin
        in_header    = byte_position_reg < POS_W'(HEADER_BYTES);
        byte_checked = byte_position_reg < POS_W'(CHECKED_BYTES);

        header_agrees_next = header_agrees_reg;
        if (byte_checked
            && header_expect(byte_position_reg[HDR_IDX_W-1:0], cfg) != byte_in.data_byte)
        begin
            header_agrees_next = 1'b0;
        end

        running_crc_next = in_header ? running_crc_reg
                                     : crc_byte(running_crc_reg, byte_in.data_byte);

        byte_position_next = (byte_position_reg != POS_MAX) ? byte_position_reg + 1'b1
                                                             : byte_position_reg;
    end

    // verdict for a package ending on this byte
    always_comb
    begin
        crc_final       = running_crc_next ^ CRC_INIT;
        expected_length = POS_W'(HEADER_BYTES) + POS_W'(cfg.payload_bytes);
        priority if (!header_agrees_next || byte_position_next < POS_W'(HEADER_BYTES))
            verdict_next = VERDICT_HEADER;
        else if (byte_position_next != expected_length)
            verdict_next = VERDICT_LENGTH;
        else if (crc_final != cfg.expected_crc)
            verdict_next = VERDICT_CRC;
        else
            verdict_next = VERDICT_OK;
    end

    // package state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            header_agrees_reg <= 1'b1;
            running_crc_reg   <= CRC_INIT;
        end
        else if (in_xfer)
        begin
            if (byte_in.final_byte)
            begin
                byte_position_reg <= '0;
                header_agrees_reg <= 1'b1;
                running_crc_reg   <= CRC_INIT;
            end
            else
            begin
                byte_position_reg <= byte_position_next;
                header_agrees_reg <= header_agrees_next;
                running_crc_reg   <= running_crc_next;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && byte_in.final_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && byte_in.final_byte)
        begin
            verdict_reg      <= verdict_next;
            computed_crc_reg <= crc_final;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.verdict      = verdict_reg;
    assign result_out.computed_crc = computed_crc_reg;

    // checks
    `FPV_ASSERT_NEXT(a_final_gives_result, clk, rst_n, in_xfer && byte_in.final_byte, result_out.valid)
    `FPV_ASSERT_NEXT(a_final_clears_count, clk, rst_n, in_xfer && byte_in.final_byte, byte_position_reg == '0)
    `FPV_ASSERT_SAME(a_held_result_stalls, clk, rst_n, result_out.valid && !result_out.ready, !byte_in.ready)
    `FPV_ASSERT_SAME(a_mismatch_needs_bytes, clk, rst_n, !header_agrees_reg, byte_position_reg != '0)

endmodule

`default_nettype wire

// ===== rtl/fpv_regs.sv =====
// apb configuration registers of the font package verifier
// depends on fpv_pkg
`default_nettype none

module fpv_regs
    import fpv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output fpv_cfg_t                   cfg
);

    fpv_cfg_t             cfg_reg;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register writes, each masked to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAGIC:    cfg_reg.magic_word     <= pwdata;
                REG_VERSION:  cfg_reg.format_version <= pwdata[15:0];
                REG_PAYLOAD:  cfg_reg.payload_bytes  <= pwdata[22:0];
                REG_CRC:      cfg_reg.expected_crc   <= pwdata;
                REG_GLYPHS:   cfg_reg.glyph_total    <= pwdata;
                REG_PIXEL_HT: cfg_reg.pixel_height   <= pwdata[15:0];
                REG_BPP:      cfg_reg.bits_per_pixel <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_MAGIC:    prdata = cfg_reg.magic_word;
            REG_VERSION:  prdata = {16'd0, cfg_reg.format_version};
            REG_PAYLOAD:  prdata = {9'd0, cfg_reg.payload_bytes};
            REG_CRC:      prdata = cfg_reg.expected_crc;
            REG_GLYPHS:   prdata = cfg_reg.glyph_total;
            REG_PIXEL_HT: prdata = {16'd0, cfg_reg.pixel_height};
            REG_BPP:      prdata = {24'd0, cfg_reg.bits_per_pixel};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== dv/tb_font_package_verifier_unit.sv =====
`timescale 1ns / 100ps
// self-checking testbench for font_package_verifier_unit: streams random font
// packages under changing register settings and checks every verdict and crc
// depends on fpv_pkg, fpv_ifs and the rtl of the verifier unit

module tb_font_package_verifier_unit;
    import fpv_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_FROM  = 1650;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_HEADER,
        SHAPE_BAD_CRC,
        SHAPE_LONG,
        SHAPE_SHORT_PAYLOAD,
        SHAPE_SHORT_HEADER,
        SHAPE_NOISE
    } package_shape_t;

    // predicts the verdict of each package and holds the verdicts still due
    class verdict_predictor;
        typedef struct packed {
            logic [1:0]  verdict;
            logic [31:0] crc;
        } verdict_rec_t;

        fpv_cfg_t         cfg;
        logic [POS_W-1:0] byte_count;
        bit               header_good;
        logic [31:0]      crc_state;
        verdict_rec_t     verdicts_due[$];
        int               errors;

        function new();
            cfg = '0;
            errors = 0;
            clear_package();
        endfunction

        function void clear_package();
            byte_count = '0;
            header_good = 1'b1;
            crc_state = CRC_INIT;
        endfunction

        // reflected crc-32, one byte
        static function logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
            crc = crc ^ {24'd0, b};
            repeat (8)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            return crc;
        endfunction

        // value that checked header byte p must carry
        function logic [7:0] header_byte(int p);
            logic [31:0] word;
            if (p < 4)
                word = cfg.magic_word >> (8 * p);
            else if (p < 6)
                word = 32'(cfg.format_version) >> (8 * (p - 4));
            else if (p < 8)
                word = 32'(HEADER_BYTES) >> (8 * (p - 6));
            else if (p < 12)
                word = 32'(cfg.payload_bytes) >> (8 * (p - 8));
            else if (p < 16)
                word = cfg.expected_crc >> (8 * (p - 12));
            else if (p < 20)
                word = cfg.glyph_total >> (8 * (p - 16));
            else if (p < 22)
                word = 32'(cfg.pixel_height) >> (8 * (p - 20));
            else
                word = 32'(cfg.bits_per_pixel);
            return word[7:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                REG_MAGIC:    cfg.magic_word = value;
                REG_VERSION:  cfg.format_version = value[15:0];
                REG_PAYLOAD:  cfg.payload_bytes = value[22:0];
                REG_CRC:      cfg.expected_crc = value;
                REG_GLYPHS:   cfg.glyph_total = value;
                REG_PIXEL_HT: cfg.pixel_height = value[15:0];
                REG_BPP:      cfg.bits_per_pixel = value[7:0];
                default:      ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [CFG_IDX_W-1:0] idx);
            case (idx)
                REG_MAGIC:    return cfg.magic_word;
                REG_VERSION:  return 32'(cfg.format_version);
                REG_PAYLOAD:  return 32'(cfg.payload_bytes);
                REG_CRC:      return cfg.expected_crc;
                REG_GLYPHS:   return cfg.glyph_total;
                REG_PIXEL_HT: return 32'(cfg.pixel_height);
                REG_BPP:      return 32'(cfg.bits_per_pixel);
                default:      return '0;
            endcase
        endfunction

        // one byte transfer into the block
        function void take_byte(logic [7:0] b, logic last);
            logic [31:0]  crc_out;
            verdict_rec_t rec;
            if (byte_count < POS_W'(HEADER_BYTES))
            begin
                if (byte_count < POS_W'(CHECKED_BYTES) && b != header_byte(int'(byte_count)))
                    header_good = 1'b0;
            end
            else
                crc_state = crc_update(crc_state, b);
            if (byte_count != POS_MAX)
                byte_count = byte_count + 1'b1;
            if (last)
            begin
                crc_out = ~crc_state;
                if (!header_good || byte_count < POS_W'(HEADER_BYTES))
                    rec.verdict = VERDICT_HEADER;
                else if (32'(byte_count) != 32'(HEADER_BYTES) + 32'(cfg.payload_bytes))
                    rec.verdict = VERDICT_LENGTH;
                else if (crc_out != cfg.expected_crc)
                    rec.verdict = VERDICT_CRC;
                else
                    rec.verdict = VERDICT_OK;
                rec.crc = crc_out;
                verdicts_due.push_back(rec);
                clear_package();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        // one result transfer out of the block
        task check_verdict(logic [1:0] verdict, logic [31:0] crc);
            verdict_rec_t want;
            if (verdicts_due.size() == 0)
            begin
                report($sformatf("result with none due: verdict %0d crc %08h", verdict, crc));
                return;
            end
            want = verdicts_due.pop_front();
            if (verdict != want.verdict)
                report($sformatf("verdict %0d, predicted %0d", verdict, want.verdict));
            if (crc != want.crc)
                report($sformatf("computed_crc %08h, predicted %08h", crc, want.crc));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    fpv_byte_if   byte_ch ();
    fpv_result_if result_ch ();

    verdict_predictor verdicts = new();

    logic [7:0] payload_buf[$];
    bit         idle_on = 1'b1;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         stall_left = 0;
    int         sent_bytes = 0;

    font_package_verifier_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_ch),
        .result_out (result_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (idle_on && $urandom_range(0, 99) < stall_pct)
            stall_left = $urandom_range(1, 13);
        result_ch.ready <= (stall_left == 0);
    end

    // check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            verdicts.check_verdict(result_ch.verdict, result_ch.computed_crc);
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        verdicts.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_read(input logic [CFG_IDX_W-1:0] idx, output logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // one byte transfer, with an optional gap in front
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (idle_on && $urandom_range(0, 99) < gap_pct)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.final_byte <= last;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        verdicts.take_byte(data, last);
        sent_bytes++;
        idle_on = sent_bytes < QUIET_FROM;
    endtask

    // build a package of the given shape around payload_buf and stream it
    task automatic send_package(input package_shape_t shape);
        logic [7:0] pkt[$];
        int         i;
        int         k;
        int         cut;
        for (i = 0; i < HEADER_BYTES; i++)
            pkt.push_back(i < CHECKED_BYTES ? verdicts.header_byte(i) : 8'($urandom));
        foreach (payload_buf[j])
            pkt.push_back(payload_buf[j]);
        case (shape)
            SHAPE_BAD_HEADER:
            begin
                k = $urandom_range(0, CHECKED_BYTES - 1);
                pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
            end
            SHAPE_BAD_CRC:
            begin
                if (payload_buf.size() == 0)
                    pkt.push_back(8'($urandom));
                else
                begin
                    k = HEADER_BYTES + $urandom_range(0, payload_buf.size() - 1);
                    pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
                end
            end
            SHAPE_LONG:
                repeat ($urandom_range(1, 5)) pkt.push_back(8'($urandom));
            SHAPE_SHORT_PAYLOAD:
            begin
                cut = payload_buf.size() > 0 ? payload_buf.size() : 1;
                repeat ($urandom_range(1, cut)) void'(pkt.pop_back());
            end
            SHAPE_SHORT_HEADER:
            begin
                cut = $urandom_range(1, HEADER_BYTES - 1);
                while (pkt.size() > cut)
                    void'(pkt.pop_back());
            end
            SHAPE_NOISE:
            begin
                pkt.delete();
                repeat ($urandom_range(1, 60)) pkt.push_back(8'($urandom));
            end
            default: ;
        endcase
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // stop sending and let every due verdict come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        while (verdicts.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        fpv_cfg_t       c;
        package_shape_t shape;
        int             phase;
        int             r;
        int             i;
        logic [31:0]    crc;
        logic [31:0]    got;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.final_byte = 1'b0;
        result_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // one-byte package, then a package that stops inside a correct header
        send_byte(8'hFF, 1'b1);
        for (i = 0; i < 20; i++)
            send_byte(verdicts.header_byte(i), i == 19);
        wait_drained();

        for (phase = 0; sent_bytes < ITEM_TARGET; phase++)
        begin
            // register settings: all zero, all at maximum but payload bytes 8388576, then random
            if (phase == 0)
                c = '0;
            else if (phase == 1)
            begin
                c.magic_word = '1;
                c.format_version = '1;
                c.payload_bytes = 23'd8388576;
                c.expected_crc = '1;
                c.glyph_total = '1;
                c.pixel_height = '1;
                c.bits_per_pixel = '1;
            end
            else
            begin
                c.magic_word = $urandom;
                c.format_version = 16'($urandom);
                c.glyph_total = $urandom;
                c.pixel_height = 16'($urandom);
                c.bits_per_pixel = 8'($urandom);
                r = $urandom_range(0, 99);
                if (phase == 2)
                    c.payload_bytes = '0;
                else if (r < 75)
                    c.payload_bytes = 23'($urandom_range(0, 40));
                else if (r < 95)
                    c.payload_bytes = 23'($urandom_range(41, 200));
                else
                    c.payload_bytes = 23'($urandom_range(300, 600));
            end

            // payload for this phase and its crc
            payload_buf.delete();
            repeat (c.payload_bytes > 1024 ? 48 : c.payload_bytes)
                payload_buf.push_back(8'($urandom));
            crc = CRC_INIT;
            foreach (payload_buf[j])
                crc = verdict_predictor::crc_update(crc, payload_buf[j]);
            if (phase >= 2)
                c.expected_crc = ($urandom_range(0, 9) == 0) ? 32'($urandom) : ~crc;

            cfg_write(REG_MAGIC, c.magic_word);
            cfg_write(REG_VERSION, 32'(c.format_version));
            cfg_write(REG_PAYLOAD, 32'(c.payload_bytes));
            cfg_write(REG_CRC, c.expected_crc);
            cfg_write(REG_GLYPHS, c.glyph_total);
            cfg_write(REG_PIXEL_HT, 32'(c.pixel_height));
            cfg_write(REG_BPP, 32'(c.bits_per_pixel));

            // register readback
            for (r = int'(REG_MAGIC); r <= int'(REG_BPP); r++)
            begin
                cfg_read(CFG_IDX_W'(r), got);
                if (got != verdicts.reg_value(CFG_IDX_W'(r)))
                    verdicts.report($sformatf("register %0d reads %08h, holds %08h",
                        r, got, verdicts.reg_value(CFG_IDX_W'(r))));
            end

            gap_pct = $urandom_range(0, 2) * 15;
            stall_pct = $urandom_range(0, 2) * 15;

            // well-formed packages most often, some broken ones and noise
            repeat ($urandom_range(3, 6))
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    shape = SHAPE_GOOD;
                else if (r < 57)
                    shape = SHAPE_BAD_HEADER;
                else if (r < 69)
                    shape = SHAPE_BAD_CRC;
                else if (r < 78)
                    shape = SHAPE_LONG;
                else if (r < 87)
                    shape = SHAPE_SHORT_PAYLOAD;
                else if (r < 93)
                    shape = SHAPE_SHORT_HEADER;
                else
                    shape = SHAPE_NOISE;
                send_package(shape);
            end
            wait_drained();
        end

        if (verdicts.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fpv_pkg.sv
rtl/fpv_ifs.sv
rtl/fpv_regs.sv
rtl/font_package_verifier_unit.sv
dv/tb_font_package_verifier_unit.sv
